// ===== design/cle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_pkg
// Character codes, request kinds and the result record of the console line
// editor.
// ----------------------------------------------------------------------------
package cle_pkg;

   // Control and line characters
   localparam logic [7:0] CharNul   = 8'h00;
   localparam logic [7:0] CharCtrlD = 8'h04;
   localparam logic [7:0] CharLf    = 8'h0A;
   localparam logic [7:0] CharCr    = 8'h0D;
   localparam logic [7:0] CharCtrlP = 8'h10;
   localparam logic [7:0] CharCtrlQ = 8'h11;
   localparam logic [7:0] CharCtrlU = 8'h15;
   localparam logic [7:0] CharDel   = 8'h7F;

   // Request kind, carried on req_tuser
   typedef enum logic [0:0] {
      OP_RX   = 1'b0,
      OP_READ = 1'b1
   } op_type;

   // Dump request codes
   localparam logic [1:0] DumpNone = 2'd0;
   localparam logic [1:0] DumpProc = 2'd1;
   localparam logic [1:0] DumpPage = 2'd2;

   // One result, most significant member first
   typedef struct packed {
      logic       line_end;
      logic       read_empty;
      logic       read_eof;
      logic [7:0] read_byte;
      logic       read_valid;
      logic       rx_dropped;
      logic       line_ready;
      logic [1:0] dump_request;
      logic [7:0] erase_count;
      logic [7:0] echo_char;
      logic       echo_valid;
   } rsp_type;

endpackage

// ===== design/console_line_editor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_line_editor
// Canonical-mode console line editor over a ring buffer with read, commit and
// edit pointers.
// ----------------------------------------------------------------------------
// Takes one request per clock when req_tready is high, received characters and
// byte reads, and registers its single result in a two-entry output stage,
// so req_tready stays high while one result waits for the consumer. The ring
// buffer is a BUF_DEPTH-byte memory with one write port at the edit pointer
// and a registered read port that keeps the byte at the read pointer ready
// ahead of the next read request; a write to that same slot is forwarded.
// Pointers count modulo 2*BUF_DEPTH. There is no clearing pass after reset.
module console_line_editor
   import cle_pkg::*;
#(
   parameter int BUF_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   // request: [7:0] rx_char, [8] first_of_read, [15:9] zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,
   // request kind: [0] opcode
   input  logic [0:0]  req_tuser,
   // result: [0] echo_valid, [8:1] echo_char, [16:9] erase_count,
   // [18:17] dump_request, [19] line_ready, [20] rx_dropped, [21] read_valid,
   // [29:22] read_byte, [30] read_eof, [31] read_empty
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   // line_end: popped byte is a newline
   output logic        rsp_tlast
);

   localparam int PW = $clog2(2 * BUF_DEPTH);
   localparam int SW = $clog2(BUF_DEPTH);
   localparam logic [PW:0] PtrMod = (PW + 1)'(2 * BUF_DEPTH);
   localparam logic [PW:0] Depth  = (PW + 1)'(BUF_DEPTH);

   // Pointer arithmetic modulo 2*BUF_DEPTH
   function automatic logic [PW-1:0] ptr_diff(input logic [PW-1:0] a,
                                              input logic [PW-1:0] b);
      logic [PW:0] t;
      t = {1'b0, a} - {1'b0, b};
      if (t[PW]) begin
         ptr_diff = t[PW-1:0] + PtrMod[PW-1:0];
      end else begin
         ptr_diff = t[PW-1:0];
      end
   endfunction

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      if ({1'b0, p} == PtrMod - 1'b1) begin
         ptr_inc = '0;
      end else begin
         ptr_inc = p + 1'b1;
      end
   endfunction

   function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
      logic [PW:0] m;
      m = PtrMod - 1'b1;
      if (p == '0) begin
         ptr_dec = m[PW-1:0];
      end else begin
         ptr_dec = p - 1'b1;
      end
   endfunction

   function automatic logic [SW-1:0] ptr_slot(input logic [PW-1:0] p);
      logic [PW:0] s;
      if ({1'b0, p} >= Depth) begin
         s = {1'b0, p} - Depth;
      end else begin
         s = {1'b0, p};
      end
      ptr_slot = s[SW-1:0];
   endfunction

   // Pointer state
   logic [PW-1:0] read_ptr_ff, read_ptr_in;
   logic [PW-1:0] commit_ptr_ff, commit_ptr_in;
   logic [PW-1:0] edit_ptr_ff, edit_ptr_in;

   // Ring buffer and its prefetched head byte
   logic [7:0]    line_store_ff [BUF_DEPTH];
   logic [7:0]    head_q_ff;
   logic          byp_ff;
   logic [7:0]    byp_data_ff;
   logic [7:0]    head_byte;
   logic          wr_en;
   logic [SW-1:0] wr_slot;
   logic [SW-1:0] rd_slot;
   logic [7:0]    wr_char;

   // Output stage
   rsp_type       out_ff, out_in;
   logic          out_valid_ff, out_valid_in;
   rsp_type       skid_ff, skid_in;
   logic          skid_valid_ff, skid_valid_in;
   rsp_type       result;

   // Request decode
   logic          accept;
   op_type        op;
   logic [7:0]    rx_char;
   logic          first_of_read;
   logic [PW-1:0] fill;
   logic [PW-1:0] edit_next;
   logic [PW-1:0] kill_cnt;
   logic [PW+7:0] kill_ext;

   assign req_tready    = !skid_valid_ff;
   assign accept        = req_tvalid && req_tready;
   assign op            = op_type'(req_tuser[0]);
   assign rx_char       = req_tdata[7:0];
   assign first_of_read = req_tdata[8];

   assign head_byte = byp_ff ? byp_data_ff : head_q_ff;
   assign fill      = ptr_diff(edit_ptr_ff, read_ptr_ff);
   assign edit_next = ptr_inc(edit_ptr_ff);
   assign kill_cnt  = ptr_diff(edit_ptr_ff, commit_ptr_ff);
   assign kill_ext  = {8'b0, kill_cnt};
   assign wr_char   = (rx_char == CharCr) ? CharLf : rx_char;
   assign wr_slot   = ptr_slot(edit_ptr_ff);
   assign rd_slot   = ptr_slot(read_ptr_in);

   // Edit and read the line, one request per pass
   always_comb begin
      result        = '0;
      read_ptr_in   = read_ptr_ff;
      commit_ptr_in = commit_ptr_ff;
      edit_ptr_in   = edit_ptr_ff;
      wr_en         = 1'b0;
      if (op == OP_RX) begin
         if (rx_char == CharCtrlP) begin
            result.dump_request = DumpProc;
         end else if (rx_char == CharCtrlQ) begin
            result.dump_request = DumpPage;
         end else if (rx_char == CharCtrlU) begin
            result.erase_count = kill_ext[7:0];
            edit_ptr_in        = commit_ptr_ff;
         end else if (rx_char == CharDel) begin
            if (edit_ptr_ff != commit_ptr_ff) begin
               edit_ptr_in        = ptr_dec(edit_ptr_ff);
               result.erase_count = 8'd1;
            end
         end else if (rx_char != CharNul && {1'b0, fill} < Depth) begin
            result.echo_valid = 1'b1;
            result.echo_char  = wr_char;
            wr_en             = 1'b1;
            edit_ptr_in       = edit_next;
            if (wr_char == CharLf || wr_char == CharCtrlD ||
                {1'b0, ptr_diff(edit_next, read_ptr_ff)} == Depth) begin
               commit_ptr_in     = edit_next;
               result.line_ready = 1'b1;
            end
         end else begin
            result.rx_dropped = 1'b1;
         end
      end else begin
         if (read_ptr_ff == commit_ptr_ff) begin
            result.read_empty = 1'b1;
         end else if (head_byte == CharCtrlD) begin
            result.read_eof = 1'b1;
            if (first_of_read) begin
               read_ptr_in = ptr_inc(read_ptr_ff);
            end
         end else begin
            read_ptr_in       = ptr_inc(read_ptr_ff);
            result.read_valid = 1'b1;
            result.read_byte  = head_byte;
            result.line_end   = (head_byte == CharLf);
         end
      end
      // Hold everything when no request is taken
      if (!accept) begin
         read_ptr_in   = read_ptr_ff;
         commit_ptr_in = commit_ptr_ff;
         edit_ptr_in   = edit_ptr_ff;
         wr_en         = 1'b0;
      end
   end

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         read_ptr_ff   <= '0;
         commit_ptr_ff <= '0;
         edit_ptr_ff   <= '0;
      end else begin
         read_ptr_ff   <= read_ptr_in;
         commit_ptr_ff <= commit_ptr_in;
         edit_ptr_ff   <= edit_ptr_in;
      end
   end

   // Write at the edit slot, prefetch the byte at the next read slot
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_store_ff[wr_slot] <= wr_char;
      end
      head_q_ff   <= line_store_ff[rd_slot];
      byp_data_ff <= wr_char;
   end

   // Forward a write that lands on the prefetched slot
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else begin
         byp_ff <= wr_en && (wr_slot == rd_slot);
      end
   end

   // Two-entry output stage
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_ff.line_end;
   assign rsp_tdata  = {out_ff.read_empty, out_ff.read_eof, out_ff.read_byte,
                        out_ff.read_valid, out_ff.rx_dropped, out_ff.line_ready,
                        out_ff.dump_request, out_ff.erase_count, out_ff.echo_char,
                        out_ff.echo_valid};

`ifndef SYNTHESIS
   // The skid entry is only ever filled behind a held result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid without a held result");

   // The buffer never holds more than BUF_DEPTH bytes
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, ptr_diff(edit_ptr_ff, read_ptr_ff)} <= Depth)
      else $error("ring buffer over-filled");

   // A read of an empty buffer leaves the read pointer alone
   a_empty_read_holds: assert property (@(posedge clock) disable iff (reset)
      accept && op == OP_READ && read_ptr_ff == commit_ptr_ff
      |=> $stable(read_ptr_ff))
      else $error("read pointer moved on an empty read");

   // A committed line takes everything typed so far
   a_commit_all: assert property (@(posedge clock) disable iff (reset)
      accept && result.line_ready |=> commit_ptr_ff == edit_ptr_ff)
      else $error("commit left uncommitted bytes behind");
`endif

endmodule
